// ===== rtl/core/vtae_pkg.sv =====
// ----------------------------------------------------------------------------
// vtae_pkg: shared types and constants of the VGA text to ANSI encoder
// Holds the cell descriptor that travels from the front end to the back end,
// the queue sizing, the line length and the byte codes of the escape sequences.
// ----------------------------------------------------------------------------
`default_nettype none

package vtae_pkg;

  // Cells on one terminal line before the line ending is sent.
  localparam int LINE_CELLS = 80;
  localparam int COL_W      = $clog2(LINE_CELLS);

  // Descriptor queue between front end and back end. The depth is a power
  // of two so that the pointers wrap on their own.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Byte codes.
  localparam logic [7:0] BYTE_ESC     = 8'h1B;
  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [7:0] BYTE_LBRACK  = 8'h5B;
  localparam logic [7:0] BYTE_M       = 8'h6D;
  localparam logic [7:0] BYTE_ZERO    = 8'h30;
  localparam logic [7:0] BYTE_THREE   = 8'h33;
  localparam logic [7:0] BYTE_FOUR    = 8'h34;
  localparam logic [7:0] BYTE_NINE    = 8'h39;

  // ANSI color numbers for the sixteen VGA colors.
  localparam logic [7:0] ANSI_COLOUR [16] = '{
    8'd30, 8'd34, 8'd32, 8'd36, 8'd31, 8'd35, 8'd33, 8'd37,
    8'd90, 8'd94, 8'd92, 8'd96, 8'd91, 8'd95, 8'd93, 8'd97
  };

  // Attribute field widths.
  localparam int FG_W = 4;
  localparam int BG_W = 3;

  // One classified cell: which escapes it needs and whether it ends a line.
  typedef struct packed {
    logic [7:0]      ch;
    logic [FG_W-1:0] fg;
    logic [BG_W-1:0] bg;
    logic            fg_send;
    logic            bg_send;
    logic            eol;
  } vtae_desc_t;

  // ASCII ones digit of a color number. The low three bits of the index pick
  // the digit; the bright colors share the ones digit of the dark ones.
  function automatic logic [7:0] colour_ones(input logic [BG_W-1:0] idx);
    logic [7:0] code;
    code = ANSI_COLOUR[{1'b0, idx}];
    return code - 8'd30 + BYTE_ZERO;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vtae_front.sv =====
// ----------------------------------------------------------------------------
// vtae_front: cell classifier
// Tracks the colours already sent and the column, and turns each accepted
// cell into a descriptor for the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module vtae_front
  import vtae_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       char_code,
  input  wire logic [7:0]       attribute,
  input  wire logic             screen_start,
  output vtae_desc_t            desc
);

  logic [FG_W-1:0]  last_fg;
  logic [BG_W-1:0]  last_bg;
  logic             fg_known;
  logic             bg_known;
  logic [COL_W-1:0] column;

  logic [FG_W-1:0]  fg;
  logic [BG_W-1:0]  bg;
  logic             fk;
  logic             bk;
  logic [COL_W-1:0] col;
  logic [COL_W:0]   col_inc;
  logic             eol;

  always_comb begin
    fg      = attribute[3:0];
    bg      = attribute[6:4];
    fk      = fg_known & ~screen_start;
    bk      = bg_known & ~screen_start;
    col     = screen_start ? '0 : column;
    col_inc = {1'b0, col} + (COL_W+1)'(1);
    eol     = (col_inc >= (COL_W+1)'(LINE_CELLS));

    desc.ch      = char_code;
    desc.fg      = fg;
    desc.bg      = bg;
    desc.fg_send = ~fk | (fg != last_fg);
    desc.bg_send = ~bk | (bg != last_bg);
    desc.eol     = eol;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_fg  <= '0;
      last_bg  <= '0;
      fg_known <= 1'b0;
      bg_known <= 1'b0;
      column   <= '0;
    end else if (accept) begin
      last_fg  <= fg;
      last_bg  <= bg;
      // A line ending resets the terminal colors, so both are forgotten.
      fg_known <= ~eol;
      bg_known <= ~eol;
      column   <= eol ? '0 : col_inc[COL_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vtae_queue.sv =====
// ----------------------------------------------------------------------------
// vtae_queue: descriptor queue
// A short first-in first-out queue of cell descriptors that decouples the
// classifier from the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module vtae_queue
  import vtae_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire vtae_desc_t wr_desc,
  input  wire logic       rd_en,
  output vtae_desc_t      rd_desc,
  output logic            full,
  output logic            valid
);

  vtae_desc_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign rd_desc = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vtae_back.sv =====
// ----------------------------------------------------------------------------
// vtae_back: byte sequencer
// Walks the queue's head descriptor one byte per cycle while the output
// register is free or being taken, through the foreground escape, background
// escape, character and line ending; the current byte stays in that register.
// ----------------------------------------------------------------------------
`default_nettype none

module vtae_back
  import vtae_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire vtae_desc_t head,
  input  wire logic       head_valid,
  output logic            head_pop,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);

  localparam logic [1:0] SEG_FG  = 2'd0;
  localparam logic [1:0] SEG_BG  = 2'd1;
  localparam logic [1:0] SEG_CHR = 2'd2;
  localparam logic [1:0] SEG_EOL = 2'd3;
  localparam logic [2:0] SUB_LAST = 3'd4;

  logic [1:0] seg;
  logic [2:0] sub;
  logic       mid;
  logic       out_valid;

  logic [1:0] seg_first;
  logic [1:0] seg_after;
  logic [1:0] cur_seg;
  logic [2:0] cur_sub;
  logic [7:0] byte_next;
  logic       is_last;
  logic       seg_end;
  logic       fire;

  always_comb begin
    if (head.fg_send) begin
      seg_first = SEG_FG;
    end else if (head.bg_send) begin
      seg_first = SEG_BG;
    end else begin
      seg_first = SEG_CHR;
    end

    cur_seg = mid ? seg : seg_first;
    cur_sub = mid ? sub : '0;

    case (cur_seg)
      SEG_FG:  seg_after = head.bg_send ? SEG_BG : SEG_CHR;
      SEG_BG:  seg_after = SEG_CHR;
      SEG_CHR: seg_after = SEG_EOL;
      default: seg_after = SEG_EOL;
    endcase

    byte_next = head.ch;
    case (cur_seg)
      SEG_FG: begin
        case (cur_sub)
          3'd0:    byte_next = BYTE_ESC;
          3'd1:    byte_next = BYTE_LBRACK;
          3'd2:    byte_next = head.fg[3] ? BYTE_NINE : BYTE_THREE;
          3'd3:    byte_next = colour_ones(head.fg[2:0]);
          default: byte_next = BYTE_M;
        endcase
      end
      SEG_BG: begin
        case (cur_sub)
          3'd0:    byte_next = BYTE_ESC;
          3'd1:    byte_next = BYTE_LBRACK;
          3'd2:    byte_next = BYTE_FOUR;
          3'd3:    byte_next = colour_ones(head.bg);
          default: byte_next = BYTE_M;
        endcase
      end
      SEG_CHR: byte_next = head.ch;
      default: begin
        case (cur_sub)
          3'd0:    byte_next = BYTE_ESC;
          3'd1:    byte_next = BYTE_LBRACK;
          3'd2:    byte_next = BYTE_ZERO;
          3'd3:    byte_next = BYTE_M;
          default: byte_next = BYTE_NEWLINE;
        endcase
      end
    endcase

    seg_end  = (cur_seg == SEG_CHR) || (cur_sub == SUB_LAST);
    is_last  = ((cur_seg == SEG_CHR) && !head.eol) ||
               ((cur_seg == SEG_EOL) && (cur_sub == SUB_LAST));
    fire     = head_valid && (!out_valid || pop);
    head_pop = fire && is_last;
  end

  assign empty = ~out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        mid       <= ~is_last;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte    <= byte_next;
      last_of_run <= is_last;
      seg         <= seg_end ? seg_after : cur_seg;
      sub         <= seg_end ? '0 : cur_sub + 3'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vga_text_to_ansi_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// vga_text_to_ansi_encoder_unit: VGA text cell to ANSI terminal byte encoder
// Converts character/attribute cells into a terminal byte stream with SGR
// color escapes and a line ending after every line of cells.
// ----------------------------------------------------------------------------
// Each accepted cell produces a run of 1 to 16 bytes: an optional foreground
// escape (ESC [ 3x/9x m), an optional background escape (ESC [ 4x m), the
// character itself, and after the last cell of a line (80 cells) the sequence
// ESC [ 0 m followed by a newline. An escape is sent only when its color
// differs from the one last sent or when the color is unknown, which is the
// case after reset, after a line ending and on a cell marked screen_start.
// The final byte of each run carries last_of_run. The output side runs at
// one byte per cycle while each waiting byte is taken, and a cell holds the
// byte sequencer until the last byte of its run has moved into the output
// register. When the sequencer is free, a cell is written into the queue
// and its first byte then into the output register that drives the ports.
// The input side takes one cell per cycle until the four-entry descriptor
// queue between the classifier and the sequencer is full; a transaction on
// either side never waits on the other except through that queue. The
// result ports are driven from a register; while a byte waits there the
// sequencer holds, and the queue keeps taking cells until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module vga_text_to_ansi_encoder_unit
  import vtae_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] attribute,
  input  wire logic       screen_start,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);

  vtae_desc_t new_desc;
  vtae_desc_t head_desc;
  logic       accept;
  logic       head_valid;
  logic       head_pop;

  // An input transaction completes when push meets a queue with room.
  assign accept = push & ~full;

  // Front end: keeps the color and column state and classifies the cell.
  vtae_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_code    (char_code),
    .attribute    (attribute),
    .screen_start (screen_start),
    .desc         (new_desc)
  );

  // Queue of classified cells.
  vtae_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_desc (new_desc),
    .rd_en   (head_pop),
    .rd_desc (head_desc),
    .full    (full),
    .valid   (head_valid)
  );

  // Back end: emits the bytes of the head cell; the cell leaves the queue
  // when its last byte moves into the output register.
  vtae_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head_desc),
    .head_valid  (head_valid),
    .head_pop    (head_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

// ===== rtl/core/vtae_checker.sv =====
// ----------------------------------------------------------------------------
// vtae_checker: port-level checks of the VGA text to ANSI encoder
// Counts cells whose runs are not yet fully delivered and checks the output
// register and queue flags against that count.
// ----------------------------------------------------------------------------
`default_nettype none

module vtae_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       push,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic       last_of_run
);

  logic [3:0] pending;
  logic       in_done;
  logic       run_done;

  assign in_done  = push & ~full;
  assign run_done = pop & ~empty & last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_done && !run_done) begin
      pending <= pending + 4'd1;
    end else if (run_done && !in_done) begin
      pending <= pending - 4'd1;
    end
  end

  // Reset leaves no byte on the result ports.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result ports not empty after reset");

  // A byte that is not taken stays as it is.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_of_run)))
    else $error("waiting result changed before it was taken");

  // No byte appears unless some cell is still owed bytes.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (pending == 4'd0) |-> empty)
    else $error("result shown with no cell outstanding");

  // The input side is only full while cells are outstanding.
  a_full_pending: assert property (@(posedge clk) disable iff (rst)
    full |-> (pending != 4'd0))
    else $error("full with no cell outstanding");

endmodule

bind vga_text_to_ansi_encoder_unit vtae_checker u_vtae_checker (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_byte    (out_byte),
  .last_of_run (last_of_run)
);

`default_nettype wire
